>>> src/sest_pkg.sv
package sest_pkg;

	localparam logic [1:0] ACT_INSERT   = 2'd0;
	localparam logic [1:0] ACT_CURRENT  = 2'd1;
	localparam logic [1:0] ACT_UPCOMING = 2'd2;
	localparam logic [1:0] ACT_NEAREST  = 2'd3;

	localparam int LIST_CAP = 64;

	typedef struct packed {
		logic [1:0]  action;
		logic [31:0] start_time;
		logic [31:0] end_time;
		logic [2:0]  location;
		logic [15:0] tag;
		logic [31:0] now_time;
		logic [6:0]  max_count;
	} req_t;

	typedef struct packed {
		logic        valid_res;
		logic        status;
		logic [15:0] entry_tag;
		logic [31:0] entry_start;
		logic [31:0] entry_end;
		logic [2:0]  entry_location;
		logic        last;
	} rsp_t;

	typedef struct packed {
		logic [31:0] start_time;
		logic [31:0] end_time;
		logic [2:0]  location;
		logic [15:0] tag;
	} entry_t;

	typedef struct packed {
		logic   ins;
		logic   rot;
		logic   append;
		entry_t new_ent;
	} cell_ctrl_t;

	// order key is start time, then location
	function automatic logic key_ge(entry_t a, entry_t b);
		return {a.start_time, a.location} >= {b.start_time, b.location};
	endfunction

	function automatic rsp_t to_rsp(entry_t e, logic lst);
		rsp_t r;
		r.valid_res      = 1'b1;
		r.status         = 1'b0;
		r.entry_tag      = e.tag;
		r.entry_start    = e.start_time;
		r.entry_end      = e.end_time;
		r.entry_location = e.location;
		r.last           = lst;
		return r;
	endfunction

endpackage

>>> src/sest_cell.sv
module sest_cell
	import sest_pkg::*;
#(
	parameter int IDX = 0,
	parameter int CW  = 8
) (
	input  logic          clk,
	input  cell_ctrl_t    ctrl,
	input  logic [CW-1:0] cnt,
	input  entry_t        left_ent,
	input  logic          left_after,
	input  entry_t        right_ent,
	input  entry_t        head_ent,
	output entry_t        ent,
	output logic          after
);

	entry_t ent_q;
	logic   occupied;
	logic   is_last;

	assign occupied = CW'(IDX) < cnt;
	assign is_last  = CW'(IDX + 1) == cnt;

	// set on every cell at or behind the insertion point
	assign after = !occupied || (!ctrl.append && key_ge(ent_q, ctrl.new_ent));
	assign ent   = ent_q;

	always_ff @(posedge clk) begin
		if (ctrl.ins && after) begin
			ent_q <= left_after ? left_ent : ctrl.new_ent;
		end else if (ctrl.rot && occupied) begin
			// rotate towards the head, last occupied cell takes the head
			ent_q <= is_last ? head_ent : right_ent;
		end
	end

endmodule

>>> src/sorted_event_schedule_table.sv
// Sorted event table held in a row of cells, kept in (start, location) order.
// An insert finds its place in every cell at once and shifts the tail by one, and
// its one result word is registered together with the shift. A query rotates the
// whole row through the head cell, one entry per cycle while the output is not
// stalled, so it steps through every stored entry whatever max_count is; the row
// ends the query in its original order. Matching entries are returned one word
// each, and a query with no match returns one word with valid_res low. An insert
// into a full table returns status high and leaves the table as it was.
module sorted_event_schedule_table
	import sest_pkg::*;
#(
	parameter int TABLE_DEPTH    = 128,
	parameter int LOCATION_COUNT = 5
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	localparam int CW = $clog2(TABLE_DEPTH + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]    state_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] k_q;
	logic [6:0]    n_q;
	logic          stop_q;
	logic          found_q;
	logic          pend_v_q;
	entry_t        pend_q;
	entry_t        last_ent_q;
	logic [1:0]    q_act_q;
	logic [31:0]   q_now_q;
	logic [6:0]    q_max_q;
	logic [2:0]    q_loc_q;
	logic          rsp_valid_q;
	rsp_t          rsp_q;

	entry_t        ent [TABLE_DEPTH];
	logic          after_v [TABLE_DEPTH];
	cell_ctrl_t    ctrl;
	entry_t        new_ent;
	entry_t        h;
	logic [2:0]    loc_c;
	logic [6:0]    max_c;
	logic          req_fire;
	logic          out_free;
	logic          full;
	logic          do_ins;
	logic          append;
	logic          rot;
	logic          list_mode;
	logic          take;
	logic          near_hit;
	logic          pend_load;
	logic          load_out;
	rsp_t          out_nx;

	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = !(state_q == ST_IDLE && out_free);
	assign req_fire  = req_valid && !req_stall;

	assign loc_c = ({1'b0, req.location} >= 4'(LOCATION_COUNT)) ?
		3'(LOCATION_COUNT - 1) : req.location;
	assign max_c = (req.max_count > 7'(LIST_CAP)) ? 7'(LIST_CAP) : req.max_count;

	assign new_ent.start_time = req.start_time;
	assign new_ent.end_time   = req.end_time;
	assign new_ent.location   = loc_c;
	assign new_ent.tag        = req.tag;

	assign full   = cnt_q >= CW'(TABLE_DEPTH);
	assign do_ins = req_fire && req.action == ACT_INSERT && !full;
	// equal to the tail key still goes behind it
	assign append = cnt_q == '0 || key_ge(new_ent, last_ent_q);
	assign rot    = state_q == ST_SCAN && out_free;

	assign ctrl.ins     = do_ins;
	assign ctrl.rot     = rot;
	assign ctrl.append  = append;
	assign ctrl.new_ent = new_ent;

	genvar gi;
	generate
		for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
			entry_t left_e;
			entry_t right_e;
			logic   left_a;
			if (gi == 0) begin : g_first
				assign left_e = new_ent;
				assign left_a = 1'b0;
			end else begin : g_mid
				assign left_e = ent[gi-1];
				assign left_a = after_v[gi-1];
			end
			if (gi == TABLE_DEPTH - 1) begin : g_end
				assign right_e = ent[0];
			end else begin : g_inner
				assign right_e = ent[gi+1];
			end
			sest_cell #(
				.IDX (gi),
				.CW  (CW)
			) u_cell (
				.clk        (clk),
				.ctrl       (ctrl),
				.cnt        (cnt_q),
				.left_ent   (left_e),
				.left_after (left_a),
				.right_ent  (right_e),
				.head_ent   (ent[0]),
				.ent        (ent[gi]),
				.after      (after_v[gi])
			);
		end
	endgenerate

	assign h = ent[0];

	assign list_mode = q_act_q == ACT_CURRENT || q_act_q == ACT_UPCOMING;
	always_comb begin
		if (q_act_q == ACT_CURRENT) begin
			take = !stop_q && n_q < q_max_q && h.start_time <= q_now_q &&
				h.end_time > q_now_q;
		end else begin
			take = n_q < q_max_q && h.start_time > q_now_q;
		end
	end
	// first earlier start wins, otherwise keep the first one at the location
	assign near_hit = h.location == q_loc_q && !found_q &&
		(h.start_time < q_now_q || !pend_v_q);
	assign pend_load = rot && (list_mode ? take : near_hit);

	always_comb begin
		load_out = 1'b0;
		out_nx   = '0;
		if (req_fire && req.action == ACT_INSERT) begin
			load_out = 1'b1;
			if (full) begin
				out_nx.status = 1'b1;
				out_nx.last   = 1'b1;
			end else begin
				out_nx = to_rsp(new_ent, 1'b1);
			end
		end else if (rot && list_mode && take && pend_v_q) begin
			load_out = 1'b1;
			out_nx   = to_rsp(pend_q, 1'b0);
		end else if (state_q == ST_DONE && out_free) begin
			load_out = 1'b1;
			if (pend_v_q) begin
				out_nx = to_rsp(pend_q, 1'b1);
			end else begin
				out_nx.last = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			k_q         <= '0;
			n_q         <= '0;
			stop_q      <= 1'b0;
			found_q     <= 1'b0;
			pend_v_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				rsp_valid_q <= load_out;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						if (req.action == ACT_INSERT) begin
							if (!full) begin
								cnt_q <= cnt_q + CW'(1);
							end
						end else begin
							k_q      <= '0;
							n_q      <= '0;
							stop_q   <= 1'b0;
							found_q  <= 1'b0;
							pend_v_q <= 1'b0;
							state_q  <= (cnt_q == '0) ? ST_DONE : ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (rot) begin
						k_q <= k_q + CW'(1);
						if (k_q == cnt_q - CW'(1)) begin
							state_q <= ST_DONE;
						end
						if (pend_load) begin
							pend_v_q <= 1'b1;
						end
						if (list_mode && take) begin
							n_q <= n_q + 7'd1;
						end
						if (q_act_q == ACT_CURRENT && h.start_time > q_now_q) begin
							stop_q <= 1'b1;
						end
						if (!list_mode && near_hit && h.start_time < q_now_q) begin
							found_q <= 1'b1;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q  <= ST_IDLE;
						pend_v_q <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			rsp_q <= out_nx;
		end
		if (pend_load) begin
			pend_q <= h;
		end
		if (do_ins && append) begin
			last_ent_q <= new_ent;
		end
		if (req_fire && req.action != ACT_INSERT) begin
			q_act_q <= req.action;
			q_now_q <= req.now_time;
			q_max_q <= max_c;
			q_loc_q <= loc_c;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_ins_count: assert property (@(posedge clk) disable iff (!arst_n)
		do_ins |=> cnt_q == $past(cnt_q) + CW'(1))
		else $error("insert did not grow the table");

	a_scan_idx: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> k_q < cnt_q)
		else $error("scan index past the stored entries");

	a_idle_pend: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !pend_v_q)
		else $error("pending word left over after a query");

endmodule

>>> tb/sorted_event_schedule_table_test.sv
`timescale 1ns / 100ps

module sorted_event_schedule_table_test
	import sest_pkg::*;
();

	localparam int TABLE_DEPTH     = 128;
	localparam int LOCATION_COUNT  = 5;
	localparam int RANDOM_ITEMS    = 385;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int SETTLE_CYCLES   = TABLE_DEPTH + 20;
	localparam int QUIET_LIMIT     = 4000;

	class schedule_scoreboard;
		logic [31:0] starts [TABLE_DEPTH];
		logic [31:0] ends   [TABLE_DEPTH];
		logic [2:0]  locs   [TABLE_DEPTH];
		logic [15:0] tags   [TABLE_DEPTH];
		int unsigned fill;
		rsp_t        pending [$];
		int unsigned errors, requests, stored, refused, listed, empties;

		function new();
			fill = 0;
			errors = 0;
			requests = 0;
			stored = 0;
			refused = 0;
			listed = 0;
			empties = 0;
		endfunction

		function bit key_below(logic [31:0] s1, logic [2:0] l1, logic [31:0] s2,
			logic [2:0] l2);
			return {s1, l1} < {s2, l2};
		endfunction

		function rsp_t entry_word(int unsigned idx);
			rsp_t r;
			r = '0;
			r.valid_res      = 1'b1;
			r.entry_tag      = tags[idx];
			r.entry_start    = starts[idx];
			r.entry_end      = ends[idx];
			r.entry_location = locs[idx];
			return r;
		endfunction

		// works out the words an accepted request will cause
		function void take_request(req_t w);
			logic [2:0]  loc;
			logic [6:0]  cap;
			int unsigned pos, i, hit, first_seen;
			bit          found, seen;
			rsp_t        word;
			rsp_t        list [$];
			requests++;
			loc = (w.location >= LOCATION_COUNT) ? 3'(LOCATION_COUNT - 1) : w.location;
			cap = (w.max_count > LIST_CAP) ? 7'(LIST_CAP) : w.max_count;
			word = '0;
			if (w.action == ACT_INSERT) begin
				if (fill >= TABLE_DEPTH) begin
					word.status = 1'b1;
					word.last = 1'b1;
					pending.push_back(word);
					refused++;
					return;
				end
				if (fill == 0)
					pos = 0;
				else if (!key_below(w.start_time, loc, starts[fill - 1], locs[fill - 1]))
					pos = fill;
				else if (!key_below(starts[0], locs[0], w.start_time, loc))
					pos = 0;
				else begin
					pos = 1;
					while (pos < fill && key_below(starts[pos], locs[pos], w.start_time, loc))
						pos++;
				end
				for (i = fill; i > pos; i--) begin
					starts[i] = starts[i - 1];
					ends[i]   = ends[i - 1];
					locs[i]   = locs[i - 1];
					tags[i]   = tags[i - 1];
				end
				starts[pos] = w.start_time;
				ends[pos]   = w.end_time;
				locs[pos]   = loc;
				tags[pos]   = w.tag;
				fill++;
				stored++;
				word = entry_word(pos);
				word.last = 1'b1;
				pending.push_back(word);
				return;
			end
			case (w.action)
				ACT_CURRENT: begin
					// sorted by start, so the scan ends at the first later start
					for (i = 0; i < fill && list.size() < cap && starts[i] <= w.now_time; i++)
						if (ends[i] > w.now_time)
							list.push_back(entry_word(i));
				end
				ACT_UPCOMING: begin
					for (i = 0; i < fill && list.size() < cap; i++)
						if (starts[i] > w.now_time)
							list.push_back(entry_word(i));
				end
				default: begin
					found = 1'b0;
					seen = 1'b0;
					hit = 0;
					first_seen = 0;
					for (i = 0; i < fill; i++) begin
						if (locs[i] == loc) begin
							if (starts[i] < w.now_time) begin
								hit = i;
								found = 1'b1;
								break;
							end
							if (!seen) begin
								seen = 1'b1;
								first_seen = i;
							end
						end
					end
					if (found)
						list.push_back(entry_word(hit));
					else if (seen)
						list.push_back(entry_word(first_seen));
				end
			endcase
			if (list.size() == 0) begin
				word = '0;
				word.last = 1'b1;
				pending.push_back(word);
				empties++;
				return;
			end
			for (i = 0; i < list.size(); i++) begin
				word = list[i];
				word.last = (i == list.size() - 1);
				pending.push_back(word);
				listed++;
			end
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				errors++;
			end
		endfunction

		function void match_response(rsp_t got);
			rsp_t want;
			if (pending.size() == 0) begin
				$error("result word with nothing expected: %h", got);
				errors++;
				return;
			end
			want = pending.pop_front();
			compare_field("valid_res", 32'(want.valid_res), 32'(got.valid_res));
			compare_field("status", 32'(want.status), 32'(got.status));
			compare_field("entry_tag", 32'(want.entry_tag), 32'(got.entry_tag));
			compare_field("entry_start", want.entry_start, got.entry_start);
			compare_field("entry_end", want.entry_end, got.entry_end);
			compare_field("entry_location", 32'(want.entry_location),
				32'(got.entry_location));
			compare_field("last", 32'(want.last), 32'(got.last));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	schedule_scoreboard sb;
	bit steady = 1'b0;
	bit hold_off_req = 1'b0;
	int unsigned hold_left = 0;
	int unsigned quiet_cycles;

	sorted_event_schedule_table #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.LOCATION_COUNT(LOCATION_COUNT)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	always #5 clk = ~clk;

	function automatic req_t make_req(logic [1:0] act, logic [31:0] st, logic [31:0] en,
		logic [2:0] loc, logic [15:0] tg, logic [31:0] now, logic [6:0] cnt);
		req_t w;
		w.action     = act;
		w.start_time = st;
		w.end_time   = en;
		w.location   = loc;
		w.tag        = tg;
		w.now_time   = now;
		w.max_count  = cnt;
		return w;
	endfunction

	function automatic req_t random_request(bit table_full);
		req_t w;
		bit   wide;
		wide = ($urandom_range(9) == 0);
		if ($urandom_range(99) < (table_full ? 25 : 55))
			w.action = ACT_INSERT;
		else begin
			case ($urandom_range(2))
				0: w.action = ACT_CURRENT;
				1: w.action = ACT_UPCOMING;
				default: w.action = ACT_NEAREST;
			endcase
		end
		w.tag = 16'($urandom);
		w.location = 3'($urandom_range(7));
		if (wide) begin
			w.start_time = $urandom;
			w.end_time   = $urandom;
			w.now_time   = $urandom;
		end else begin
			// crowded time window so the queries find overlaps
			w.start_time = $urandom_range(3000);
			if ($urandom_range(4) == 0)
				w.end_time = $urandom_range(3000);
			else
				w.end_time = w.start_time + $urandom_range(800);
			w.now_time = $urandom_range(3800);
		end
		if ($urandom_range(2) == 0)
			w.max_count = 7'($urandom_range(127));
		else
			w.max_count = 7'($urandom_range(1, 10));
		return w;
	endfunction

	task automatic send_request(req_t w);
		while (!steady && $urandom_range(99) < 19) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req <= w;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		sb.take_request(w);
		@(negedge clk);
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		rsp_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold_left = HOLD_OFF_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else
				rsp_stall <= !steady && ($urandom_range(99) < 19);
		end
	end

	always @(posedge clk)
		if (arst_n && rsp_valid && !rsp_stall)
			sb.match_response(rsp);

	initial begin
		quiet_cycles = 0;
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("status: fail");
		$finish;
	end

	initial begin
		int idx;
		sb = new();
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// queries on an empty table
		send_request(make_req(ACT_CURRENT, 0, 0, 0, 0, 5, 10));
		send_request(make_req(ACT_UPCOMING, 0, 0, 0, 0, 0, 127));
		send_request(make_req(ACT_NEAREST, 0, 0, 2, 0, 50, 0));
		// inserts: ties on start, equal keys, front, back, out of range location
		send_request(make_req(ACT_INSERT, 100, 200, 2, 16'h0000, 0, 0));
		send_request(make_req(ACT_INSERT, 100, 300, 1, 16'hffff, 0, 0));
		send_request(make_req(ACT_INSERT, 100, 150, 2, 16'h1234, 0, 0));
		send_request(make_req(ACT_INSERT, 0, 32'hffff_ffff, 0, 16'h0001, 0, 0));
		send_request(make_req(ACT_INSERT, 32'hffff_ffff, 0, 7, 16'h8000, 0, 0));
		send_request(make_req(ACT_NEAREST, 0, 0, 3, 0, 500, 0));
		send_request(make_req(ACT_INSERT, 100, 120, 3, 16'h00ff, 0, 0));
		send_request(make_req(ACT_INSERT, 100, 110, 1, 16'h0f0f, 0, 0));
		send_request(make_req(ACT_INSERT, 150, 150, 5, 16'h7fff, 0, 0));
		send_request(make_req(ACT_INSERT, 0, 50, 0, 16'hff00, 0, 0));
		// list queries: saturated count, zero count, early stop on count
		send_request(make_req(ACT_CURRENT, 0, 0, 0, 0, 150, 127));
		send_request(make_req(ACT_CURRENT, 0, 0, 0, 0, 100, 0));
		send_request(make_req(ACT_CURRENT, 0, 0, 0, 0, 0, 1));
		send_request(make_req(ACT_UPCOMING, 0, 0, 0, 0, 0, 64));
		send_request(make_req(ACT_UPCOMING, 0, 0, 0, 0, 32'hffff_ffff, 127));
		send_request(make_req(ACT_UPCOMING, 0, 0, 0, 0, 99, 2));
		// nearest: earlier start found, fallback to first at location
		send_request(make_req(ACT_NEAREST, 0, 0, 2, 0, 150, 0));
		send_request(make_req(ACT_NEAREST, 0, 0, 6, 0, 0, 0));
		send_request(make_req(ACT_NEAREST, 0, 0, 3, 0, 100, 0));
		send_request(make_req(ACT_NEAREST, 0, 0, 0, 0, 0, 0));

		for (idx = 0; idx < RANDOM_ITEMS; idx++) begin
			steady = (idx >= 150 && idx < 230);
			if (idx == 100)
				hold_off_req = 1'b1;
			send_request(random_request(sb.fill >= TABLE_DEPTH));
		end
		req_valid <= 1'b0;

		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("sent %0d requests: %0d events stored, %0d inserts refused as table full",
			sb.requests, sb.stored, sb.refused);
		$display("%0d entry words from queries, %0d empty answers, %0d mismatches",
			sb.listed, sb.empties, sb.errors);
		if (sb.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
